@@ rtl/fcw_pkg.sv @@
// ----------------------------------------------------------------------------
// fcw_pkg
// Types, codes and constants shared by the FAT12 cluster chain walker.
// ----------------------------------------------------------------------------
package fcw_pkg;

   localparam int FAT_BYTES_DEF = 8192;
   localparam int FAT_ADDR_W    = 13;
   localparam int CLUSTER_SHIFT = 12;
   localparam int SEG_W         = 13;

   localparam logic [SEG_W-1:0] CLUSTER_BYTES = SEG_W'(1 << CLUSTER_SHIFT);
   localparam logic [11:0]      CHAIN_END     = 12'hFF8;

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_STEP  = 2'd2;

   localparam logic [2:0] STAT_ACCEPTED  = 3'd0;
   localparam logic [2:0] STAT_MORE      = 3'd1;
   localparam logic [2:0] STAT_SIZE_DONE = 3'd2;
   localparam logic [2:0] STAT_CHAIN_END = 3'd3;
   localparam logic [2:0] STAT_TOO_LARGE = 3'd4;
   localparam logic [2:0] STAT_IDLE      = 3'd5;

   localparam logic CSR_DATA_START   = 1'b0;
   localparam logic CSR_BUFFER_LIMIT = 1'b1;

   localparam logic [15:0] DATA_START_RST   = 16'd33;
   localparam logic [31:0] BUFFER_LIMIT_RST = 32'd1048576;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [FAT_ADDR_W-1:0] fat_addr;
      logic [7:0]            fat_byte;
      logic [11:0]           start_cluster;
      logic [31:0]           byte_length;
   } fcw_req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [31:0]      clus_offset;
      logic [SEG_W-1:0] segment_bytes;
      logic [11:0]      link_cluster;
      logic [31:0]      total_bytes;
      logic             last;
   } fcw_rsp_type;

   typedef struct packed {
      logic                  wr_en;
      logic [FAT_ADDR_W-1:0] wr_addr;
      logic [7:0]            wr_data;
      logic                  rd_en;
      logic [FAT_ADDR_W-1:0] rd_addr;
   } fcw_mem_req_type;

endpackage

@@ rtl/fcw_fat_mem.sv @@
// ----------------------------------------------------------------------------
// fcw_fat_mem
// FAT byte store: one write port, one byte-pair read with registered data.
// ----------------------------------------------------------------------------
module fcw_fat_mem #(
   parameter int FAT_BYTES = fcw_pkg::FAT_BYTES_DEF
) (
   input  logic                    clock,
   input  fcw_pkg::fcw_mem_req_type mem_req,
   output logic [15:0]             rd_word
);
   import fcw_pkg::*;

   localparam int AW = $clog2(FAT_BYTES);
   localparam logic [FAT_ADDR_W:0] LIMIT = (FAT_ADDR_W + 1)'(FAT_BYTES);

   logic [7:0]            mem_ff [FAT_BYTES];
   logic [7:0]            lo_ff;
   logic [7:0]            hi_ff;
   logic                  lo_ok_ff;
   logic                  hi_ok_ff;
   logic [FAT_ADDR_W:0]   hi_addr_wide;
   logic [FAT_ADDR_W-1:0] hi_addr;
   logic                  wr_ok;

   assign hi_addr_wide = {1'b0, mem_req.rd_addr} + (FAT_ADDR_W + 1)'(1);
   assign hi_addr      = hi_addr_wide[FAT_ADDR_W-1:0];
   assign wr_ok        = ({1'b0, mem_req.wr_addr} < LIMIT);

   always_ff @(posedge clock) begin
      if (mem_req.wr_en && wr_ok) begin
         mem_ff[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         lo_ff    <= mem_ff[mem_req.rd_addr[AW-1:0]];
         hi_ff    <= mem_ff[hi_addr[AW-1:0]];
         lo_ok_ff <= ({1'b0, mem_req.rd_addr} < LIMIT);
         hi_ok_ff <= (hi_addr_wide < LIMIT);
      end
   end

   assign rd_word = {(hi_ok_ff ? hi_ff : 8'd0), (lo_ok_ff ? lo_ff : 8'd0)};

endmodule

@@ rtl/fat12_cluster_chain_walker.sv @@
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker
// Follows a FAT12 cluster chain held in an on-chip FAT byte store.
// ----------------------------------------------------------------------------
// Each request passes through the transfer cycle, in which a step item
// issues the read of its two FAT bytes from the synchronous byte store, and
// the execute state, in which the 12-bit entry is unpacked and the result is
// loaded into the output register. The execute state stretches for as long
// as the output register still holds an untaken result. The FAT store is not
// cleared at reset; bytes must be written before a walk reads them.
module fat12_cluster_chain_walker #(
   parameter int FAT_BYTES = fcw_pkg::FAT_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fcw_pkg::fcw_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fcw_pkg::fcw_rsp_type rsp_data,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [31:0]          csr_wdata
);
   import fcw_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic            state_ff, state_in;
   fcw_req_type     req_ff, req_in;
   logic            walk_active_ff, walk_active_in;
   logic [11:0]     cur_cluster_ff, cur_cluster_in;
   logic [31:0]     bytes_done_ff, bytes_done_in;
   logic [31:0]     target_size_ff, target_size_in;
   logic [15:0]     data_start_ff;
   logic [31:0]     buffer_limit_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   fcw_rsp_type     rsp_data_ff, rsp_data_in;

   fcw_mem_req_type mem_req;
   logic [15:0]     rd_word;
   logic            accept;
   logic            out_free;
   logic            fire;
   logic [31:0]     sector;
   logic [31:0]     remaining;
   logic [SEG_W-1:0] seg;
   logic [31:0]     done_next;
   logic [11:0]     next_cl;
   logic [FAT_ADDR_W-1:0] entry_off;

   fcw_fat_mem #(
      .FAT_BYTES(FAT_BYTES)
   ) u_fat_mem (
      .clock  (clock),
      .mem_req(mem_req),
      .rd_word(rd_word)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = (state_ff == S_EXEC) && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign entry_off = FAT_ADDR_W'(cur_cluster_ff) + FAT_ADDR_W'(cur_cluster_ff[11:1]);

   always_comb begin
      mem_req.wr_en   = accept && (req_data.req_type == REQ_WRITE);
      mem_req.wr_addr = req_data.fat_addr;
      mem_req.wr_data = req_data.fat_byte;
      mem_req.rd_en   = accept && (req_data.req_type == REQ_STEP);
      mem_req.rd_addr = entry_off;
   end

   always_comb begin
      sector    = 32'(data_start_ff) + 32'(cur_cluster_ff) - 32'd2;
      remaining = target_size_ff - bytes_done_ff;
      seg       = (remaining < 32'(CLUSTER_BYTES)) ? remaining[SEG_W-1:0] : CLUSTER_BYTES;
      done_next = bytes_done_ff + 32'(seg);
      next_cl   = cur_cluster_ff[0] ? rd_word[15:4] : rd_word[11:0];
   end

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      walk_active_in = walk_active_ff;
      cur_cluster_in = cur_cluster_ff;
      bytes_done_in  = bytes_done_ff;
      target_size_in = target_size_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;

      if (accept) begin
         req_in   = req_data;
         state_in = S_EXEC;
      end

      if (fire) begin
         state_in     = S_IDLE;
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         unique case (req_ff.req_type)
            REQ_WRITE: begin
               rsp_data_in.status = STAT_ACCEPTED;
            end
            REQ_START: begin
               if (req_ff.byte_length > buffer_limit_ff) begin
                  walk_active_in     = 1'b0;
                  rsp_data_in.status = STAT_TOO_LARGE;
               end else begin
                  cur_cluster_in     = req_ff.start_cluster;
                  bytes_done_in      = '0;
                  target_size_in     = req_ff.byte_length;
                  walk_active_in     = (req_ff.byte_length != '0);
                  rsp_data_in.status = STAT_ACCEPTED;
                  rsp_data_in.last   = (req_ff.byte_length == '0);
               end
            end
            REQ_STEP: begin
               if (walk_active_ff) begin
                  rsp_data_in.clus_offset   = sector << CLUSTER_SHIFT;
                  rsp_data_in.segment_bytes = seg;
                  rsp_data_in.link_cluster  = next_cl;
                  rsp_data_in.total_bytes   = done_next;
                  bytes_done_in             = done_next;
                  cur_cluster_in            = next_cl;
                  priority if (done_next >= target_size_ff) begin
                     rsp_data_in.status = STAT_SIZE_DONE;
                     rsp_data_in.last   = 1'b1;
                     walk_active_in     = 1'b0;
                  end else if (next_cl >= CHAIN_END) begin
                     rsp_data_in.status = STAT_CHAIN_END;
                     rsp_data_in.last   = 1'b1;
                     walk_active_in     = 1'b0;
                  end else begin
                     rsp_data_in.status = STAT_MORE;
                  end
               end else begin
                  rsp_data_in.status = STAT_IDLE;
               end
            end
            default: begin
               rsp_data_in.status = STAT_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         walk_active_ff  <= 1'b0;
         cur_cluster_ff  <= '0;
         bytes_done_ff   <= '0;
         target_size_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
         data_start_ff   <= DATA_START_RST;
         buffer_limit_ff <= BUFFER_LIMIT_RST;
      end else begin
         state_ff       <= state_in;
         walk_active_ff <= walk_active_in;
         cur_cluster_ff <= cur_cluster_in;
         bytes_done_ff  <= bytes_done_in;
         target_size_ff <= target_size_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_DATA_START:   data_start_ff   <= csr_wdata[15:0];
               CSR_BUFFER_LIMIT: buffer_limit_ff <= csr_wdata;
               default:          ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ rtl/fcw_checker.sv @@
// ----------------------------------------------------------------------------
// fcw_checker
// Port-level checks for the FAT12 cluster chain walker.
// ----------------------------------------------------------------------------
module fcw_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input fcw_pkg::fcw_rsp_type rsp_data
);
   import fcw_pkg::*;

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in flight");

   a_last_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |->
         rsp_data.status == STAT_ACCEPTED || rsp_data.status == STAT_SIZE_DONE ||
         rsp_data.status == STAT_CHAIN_END)
      else $error("last flag on a non-final status");

   a_more_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STAT_MORE |->
         !rsp_data.last && rsp_data.segment_bytes == CLUSTER_BYTES)
      else $error("short segment reported with more to follow");

   a_no_segment_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STAT_TOO_LARGE || rsp_data.status == STAT_IDLE) |->
         rsp_data.clus_offset == '0 && rsp_data.segment_bytes == '0 &&
         rsp_data.total_bytes == '0 && !rsp_data.last)
      else $error("segment fields set on a non-segment result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind fat12_cluster_chain_walker fcw_checker u_fcw_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);
